FILE: hdl/lsi_pkg.sv
// shared types and constants for the limit switch interlock
`default_nettype none

package lsi_pkg;

  // configuration register file
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] RegTripCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] RegReleaseCount = 1'b1;

  localparam logic [CfgW-1:0] TripCountRst    = 8'd3;
  localparam logic [CfgW-1:0] ReleaseCountRst = 8'd20;

  // request codes
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqReset = 1'b1;

  // status of one end switch for the current word
  typedef struct packed {
    logic fired;
    logic lock;
  } end_status_t;

endpackage

`default_nettype wire

FILE: hdl/lsi_if.sv
// valid/ready channels for request words and result words
`default_nettype none

interface lsi_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic cw_level;
  logic ccw_level;
  logic org_level;

  modport source (output valid, req_type, cw_level, ccw_level, org_level, input ready);
  modport sink   (input valid, req_type, cw_level, ccw_level, org_level, output ready);
endinterface

interface lsi_out_if;
  logic valid;
  logic ready;
  logic alarm_active;
  logic cw_blocked;
  logic ccw_blocked;
  logic stop_pulse;
  logic cw_tripped;
  logic ccw_tripped;
  logic origin_pulse;

  modport source (output valid, alarm_active, cw_blocked, ccw_blocked, stop_pulse,
                  cw_tripped, ccw_tripped, origin_pulse, input ready);
  modport sink   (input valid, alarm_active, cw_blocked, ccw_blocked, stop_pulse,
                  cw_tripped, ccw_tripped, origin_pulse, output ready);
endinterface

`default_nettype wire

FILE: hdl/lsi_end.sv
// one end switch: trip and release qualifiers with lock and arm flags
`default_nettype none

module lsi_end #(
  parameter int unsigned CounterMax = 255
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    step_i,
  input  wire logic                    is_reset_i,
  input  wire logic                    level_i,
  input  wire logic                    alarm_i,
  input  wire logic [lsi_pkg::CfgW-1:0] trip_thr_i,
  input  wire logic [lsi_pkg::CfgW-1:0] rel_thr_i,
  output lsi_pkg::end_status_t         status_o
);

  localparam int unsigned CntW = $clog2(CounterMax + 1);
  localparam int unsigned CmpW = (CntW > lsi_pkg::CfgW) ? CntW : lsi_pkg::CfgW;

  logic [CntW-1:0] trip_q, trip_d, trip_inc;
  logic [CntW-1:0] rel_q, rel_d, rel_inc;
  logic            lock_q, lock_d;
  logic            armed_q, armed_d;
  logic            fired;

  assign trip_inc = (trip_q < CntW'(CounterMax)) ? trip_q + 1'b1 : trip_q;
  assign rel_inc  = (rel_q < CntW'(CounterMax)) ? rel_q + 1'b1 : rel_q;

  always_comb begin
    trip_d  = trip_q;
    rel_d   = rel_q;
    lock_d  = lock_q;
    armed_d = armed_q;
    fired   = 1'b0;
    if (step_i) begin
      if (is_reset_i) begin
        trip_d = '0;
        if (!level_i) begin
          lock_d  = 1'b0;
          armed_d = 1'b1;
          rel_d   = '0;
        end
      end else if (level_i) begin
        rel_d = '0;
        if (armed_q && !lock_q) begin
          trip_d = trip_inc;
          if (CmpW'(trip_inc) >= CmpW'(trip_thr_i)) begin
            lock_d  = 1'b1;
            armed_d = 1'b0;
            fired   = 1'b1;
          end
        end
      end else begin
        trip_d = '0;
        if (!armed_q) begin
          rel_d = rel_inc;
          if (CmpW'(rel_inc) >= CmpW'(rel_thr_i)) begin
            armed_d = 1'b1;
            if (!alarm_i) lock_d = 1'b0;
          end
        end else if (!alarm_i) begin
          lock_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_q  <= '0;
      rel_q   <= '0;
      lock_q  <= 1'b0;
      armed_q <= 1'b1;
    end else begin
      trip_q  <= trip_d;
      rel_q   <= rel_d;
      lock_q  <= lock_d;
      armed_q <= armed_d;
    end
  end

  assign status_o.fired = fired;
  assign status_o.lock  = lock_d;

endmodule

`default_nettype wire

FILE: hdl/limit_switch_interlock.sv
// top level of the limit switch interlock
`default_nettype none

// Each request word is either a sample tick or an alarm reset command and
// carries the CW, CCW and origin switch levels. On a tick, an armed and
// unlocked end switch seen high for trip_count consecutive ticks trips: it
// locks its direction, disarms, sets the alarm latch and raises stop_pulse.
// A tripped end re-arms after release_count consecutive low ticks; a lock
// clears on a low tick only while no alarm is latched. CW is handled before
// CCW, so an alarm set by CW on a tick already holds the CCW lock. The origin
// switch gives one origin_pulse after trip_count high ticks and rearms when
// it goes low. A reset command clears the alarm and both trip counters and
// unlocks and re-arms every end whose switch is low in that word. Every
// word gives exactly one result word. A word is held in the input register,
// then all state and the result are updated together into the output
// register, and one word is taken every cycle while the result side keeps
// up; the output register stalls the input side only when a result is
// waiting and not taken. Counters saturate at COUNTER_MAX. Configuration
// writes take effect at once and are meant for idle periods only.
module limit_switch_interlock #(
  parameter int unsigned COUNTER_MAX = 255
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lsi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [lsi_pkg::CfgW-1:0]    cfg_data_i,
  lsi_in_if.sink                          in_i,
  lsi_out_if.source                       out_o
);

  localparam int unsigned CntW = $clog2(COUNTER_MAX + 1);
  localparam int unsigned CmpW = (CntW > lsi_pkg::CfgW) ? CntW : lsi_pkg::CfgW;

  // configuration registers
  logic [lsi_pkg::CfgW-1:0] trip_cnt_q, rel_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_cnt_q <= lsi_pkg::TripCountRst;
      rel_cnt_q  <= lsi_pkg::ReleaseCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsi_pkg::RegTripCount:    trip_cnt_q <= cfg_data_i;
        lsi_pkg::RegReleaseCount: rel_cnt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic in_vld_q;
  logic req_q, cw_q, ccw_q, org_q;
  logic adv, fire, is_reset;

  assign adv         = !out_o.valid || out_o.ready;
  assign fire        = in_vld_q && adv;
  assign in_i.ready  = !in_vld_q || adv;
  assign is_reset    = (req_q == lsi_pkg::ReqReset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q <= in_i.req_type;
      cw_q  <= in_i.cw_level;
      ccw_q <= in_i.ccw_level;
      org_q <= in_i.org_level;
    end
  end

  // end switches, cw first so ccw sees an alarm cw raised on the same tick
  logic                 alarm_q, alarm_d, alarm_mid;
  lsi_pkg::end_status_t cw_st, ccw_st;

  assign alarm_mid = alarm_q || cw_st.fired;

  lsi_end #(.CounterMax(COUNTER_MAX)) u_cw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fire),
    .is_reset_i (is_reset),
    .level_i    (cw_q),
    .alarm_i    (alarm_q),
    .trip_thr_i (trip_cnt_q),
    .rel_thr_i  (rel_cnt_q),
    .status_o   (cw_st)
  );

  lsi_end #(.CounterMax(COUNTER_MAX)) u_ccw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fire),
    .is_reset_i (is_reset),
    .level_i    (ccw_q),
    .alarm_i    (alarm_mid),
    .trip_thr_i (trip_cnt_q),
    .rel_thr_i  (rel_cnt_q),
    .status_o   (ccw_st)
  );

  // alarm latch
  always_comb begin
    alarm_d = alarm_q;
    if (fire) begin
      if (is_reset) alarm_d = 1'b0;
      else          alarm_d = alarm_mid || ccw_st.fired;
    end
  end

  // origin qualifier, untouched by reset commands
  logic [CntW-1:0] org_cnt_q, org_cnt_d, org_inc;
  logic            org_seen_q, org_seen_d;
  logic            org_fired;

  assign org_inc = (org_cnt_q < CntW'(COUNTER_MAX)) ? org_cnt_q + 1'b1 : org_cnt_q;

  always_comb begin
    org_cnt_d  = org_cnt_q;
    org_seen_d = org_seen_q;
    org_fired  = 1'b0;
    if (fire && !is_reset) begin
      if (org_q) begin
        org_cnt_d = org_inc;
        if ((CmpW'(org_inc) >= CmpW'(trip_cnt_q)) && !org_seen_q) begin
          org_seen_d = 1'b1;
          org_fired  = 1'b1;
        end
      end else begin
        org_cnt_d  = '0;
        org_seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q    <= 1'b0;
      org_cnt_q  <= '0;
      org_seen_q <= 1'b0;
    end else begin
      alarm_q    <= alarm_d;
      org_cnt_q  <= org_cnt_d;
      org_seen_q <= org_seen_d;
    end
  end

  // result register
  logic out_vld_q;
  logic alarm_o_q, cw_blk_q, ccw_blk_q, stop_q, cw_trip_q, ccw_trip_q, org_pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      alarm_o_q   <= alarm_d;
      cw_blk_q    <= cw_st.lock;
      ccw_blk_q   <= ccw_st.lock;
      stop_q      <= cw_st.fired || ccw_st.fired;
      cw_trip_q   <= cw_st.fired;
      ccw_trip_q  <= ccw_st.fired;
      org_pulse_q <= org_fired;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.alarm_active = alarm_o_q;
  assign out_o.cw_blocked   = cw_blk_q;
  assign out_o.ccw_blocked  = ccw_blk_q;
  assign out_o.stop_pulse   = stop_q;
  assign out_o.cw_tripped   = cw_trip_q;
  assign out_o.ccw_tripped  = ccw_trip_q;
  assign out_o.origin_pulse = org_pulse_q;

  // a trip always shows up with its lock and the alarm
  a_trip_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.cw_tripped || out_o.ccw_tripped) |->
      out_o.alarm_active && (!out_o.cw_tripped || out_o.cw_blocked) &&
      (!out_o.ccw_tripped || out_o.ccw_blocked))
    else $error("trip without lock or alarm");

  // the alarm latch only drops on a reset command
  a_alarm_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(alarm_q) |-> $past(fire && is_reset))
    else $error("alarm cleared without reset command");

  // a reset command produces no pulses and leaves the alarm clear
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_reset |=>
      !out_o.stop_pulse && !out_o.origin_pulse && !out_o.alarm_active)
    else $error("pulse on reset command");

  // the stop pulse covers exactly the two end trips
  a_stop_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.stop_pulse == (out_o.cw_tripped || out_o.ccw_tripped)))
    else $error("stop pulse mismatch");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// testbench for the limit switch interlock: queued request words, a status predictor, idling
`default_nettype none

module tb_top;

  // request words and status words as the predictor sees them
  typedef struct packed {
    logic req_type;
    logic cw;
    logic ccw;
    logic org;
  } req_word_t;

  typedef struct packed {
    logic alarm;
    logic cw_blk;
    logic ccw_blk;
    logic stop;
    logic cw_trip;
    logic ccw_trip;
    logic org_pulse;
  } status_word_t;

  localparam logic [7:0] CounterMax = 8'd255;
  localparam int IdlePct    = 28;    // chance in percent that a side idles in a cycle
  localparam int HoldCycles = 150;   // long result-side hold-off
  localparam int QuietLimit = 1000;  // cycles with no word moving before the run is dropped
  localparam int TailCycles = 8;     // cycles waited at the end after draining
  localparam int MaxReports = 10;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [lsi_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [lsi_pkg::CfgW-1:0] cfg_data_i;

  lsi_in_if  in_bus ();
  lsi_out_if out_bus ();

  limit_switch_interlock dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // words waiting to be offered, and status words waiting to come out
  req_word_t    pending_words[$];
  status_word_t awaited_status[$];

  logic in_fire   = 1'b0;  // a request word moved at the last rising edge
  logic calm      = 1'b0;  // no idling on either side while set
  logic hold_req  = 1'b0;  // asks the result side for one long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  // ---------------------------------------------------------------------------
  // predictor state: register copies and the per-end counters and flags
  // ---------------------------------------------------------------------------
  logic [7:0] trip_cfg, rel_cfg;
  logic [7:0] cw_trip_cnt, ccw_trip_cnt, cw_rel_cnt, ccw_rel_cnt, org_cnt;
  logic       cw_lock, ccw_lock, cw_armed, ccw_armed, org_seen, alarm;

  function automatic logic [7:0] bump(logic [7:0] v);
    return (v < CounterMax) ? v + 8'd1 : CounterMax;
  endfunction

  // one end switch on a sample tick; the alarm latch is shared, so a trip
  // on the cw end is already visible when the ccw end is handled
  task automatic end_switch_tick(input logic level, inout logic [7:0] trip_cnt,
                                 inout logic [7:0] rel_cnt, inout logic lock,
                                 inout logic armed, output logic fired);
    fired = 1'b0;
    if (level) begin
      rel_cnt = 8'd0;
      if (armed && !lock) begin
        trip_cnt = bump(trip_cnt);
        // counter is bumped before the compare, so a zero threshold acts as one
        if (trip_cnt >= trip_cfg) begin
          lock  = 1'b1;
          armed = 1'b0;
          alarm = 1'b1;
          fired = 1'b1;
        end
      end
    end else begin
      trip_cnt = 8'd0;
      if (!armed) begin
        rel_cnt = bump(rel_cnt);
        if (rel_cnt >= rel_cfg) begin
          armed = 1'b1;
          if (!alarm) lock = 1'b0;
        end
      end else if (!alarm) begin
        lock = 1'b0;
      end
    end
  endtask

  // advance the interlock by one request word and give its status word
  task automatic advance_interlock(input req_word_t w, output status_word_t s);
    logic cw_f, ccw_f, org_f;
    cw_f  = 1'b0;
    ccw_f = 1'b0;
    org_f = 1'b0;
    if (w.req_type == lsi_pkg::ReqReset) begin
      // reset command: alarm and trip counters clear, a pressed end keeps its lock
      alarm        = 1'b0;
      cw_trip_cnt  = 8'd0;
      ccw_trip_cnt = 8'd0;
      if (!w.cw) begin
        cw_lock    = 1'b0;
        cw_armed   = 1'b1;
        cw_rel_cnt = 8'd0;
      end
      if (!w.ccw) begin
        ccw_lock    = 1'b0;
        ccw_armed   = 1'b1;
        ccw_rel_cnt = 8'd0;
      end
    end else begin
      end_switch_tick(w.cw, cw_trip_cnt, cw_rel_cnt, cw_lock, cw_armed, cw_f);
      end_switch_tick(w.ccw, ccw_trip_cnt, ccw_rel_cnt, ccw_lock, ccw_armed, ccw_f);
      if (w.org) begin
        // origin counter holds at the top instead of wrapping
        org_cnt = bump(org_cnt);
        if (org_cnt >= trip_cfg && !org_seen) begin
          org_seen = 1'b1;
          org_f    = 1'b1;
        end
      end else begin
        org_cnt  = 8'd0;
        org_seen = 1'b0;
      end
    end
    s.alarm     = alarm;
    s.cw_blk    = cw_lock;
    s.ccw_blk   = ccw_lock;
    s.stop      = cw_f | ccw_f;
    s.cw_trip   = cw_f;
    s.ccw_trip  = ccw_f;
    s.org_pulse = org_f;
  endtask

  // ---------------------------------------------------------------------------
  // request side: offer queued words, hold a word until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_words
    req_word_t w;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        w = pending_words.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.req_type  <= w.req_type;
        in_bus.cw_level  <= w.cw;
        in_bus.ccw_level <= w.ccw;
        in_bus.org_level <= w.org;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random ready, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_bus.ready <= 1'b0;
      hold_left     <= HoldCycles - 1;
      hold_done     <= 1'b1;
    end else begin
      out_bus.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // sampling at the rising edge: predict on taken requests, check results,
  // watchdog on cycles where nothing moves
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_words
    req_word_t    w;
    status_word_t want, got;
    logic         out_fire, bad;
    in_fire  = rst_ni && in_bus.valid && in_bus.ready;
    out_fire = rst_ni && out_bus.valid && out_bus.ready;
    if (in_fire) begin
      w.req_type = in_bus.req_type;
      w.cw       = in_bus.cw_level;
      w.ccw      = in_bus.ccw_level;
      w.org      = in_bus.org_level;
      advance_interlock(w, want);
      awaited_status.push_back(want);
    end
    if (out_fire) begin
      got.alarm     = out_bus.alarm_active;
      got.cw_blk    = out_bus.cw_blocked;
      got.ccw_blk   = out_bus.ccw_blocked;
      got.stop      = out_bus.stop_pulse;
      got.cw_trip   = out_bus.cw_tripped;
      got.ccw_trip  = out_bus.ccw_tripped;
      got.org_pulse = out_bus.origin_pulse;
      if (awaited_status.size() == 0) begin
        if (mismatches < MaxReports)
          $display("unexpected status word %b (alarm,cw_blk,ccw_blk,stop,cw,ccw,org)", got);
        mismatches++;
      end else begin
        want = awaited_status.pop_front();
        bad = (got.alarm !== want.alarm) || (got.cw_blk !== want.cw_blk) ||
              (got.ccw_blk !== want.ccw_blk) || (got.stop !== want.stop) ||
              (got.cw_trip !== want.cw_trip) || (got.ccw_trip !== want.ccw_trip) ||
              (got.org_pulse !== want.org_pulse);
        if (bad) begin
          if (mismatches < MaxReports)
            $display("status mismatch: want %b got %b (alarm,cw_blk,ccw_blk,stop,cw,ccw,org)",
                     want, got);
          mismatches++;
        end
      end
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int run_length(int thr, int tail);
    // half the runs land within one of the threshold, the rest anywhere from one up to the threshold plus tail
    if ($urandom_range(0, 1)) return $urandom_range(thr + 1, (thr > 1) ? thr - 1 : 1);
    return $urandom_range(1, thr + tail);
  endfunction

  task automatic push_word(logic req, logic cw, logic ccw, logic org);
    req_word_t w;
    w.req_type = req;
    w.cw       = cw;
    w.ccw      = ccw;
    w.org      = org;
    pending_words.push_back(w);
  endtask

  // switch levels held in runs around the thresholds, with some reset
  // commands and some fully random words mixed in
  task automatic queue_random(int n, int noise_pct, int reset_pct);
    logic       lv [3];
    int         left [3];
    int         trip_eff, rel_eff, roll;
    logic [3:0] bits;
    trip_eff = (trip_cfg == 8'd0) ? 1 : int'(trip_cfg);
    rel_eff  = (rel_cfg == 8'd0) ? 1 : int'(rel_cfg);
    for (int i = 0; i < 3; i++) begin
      lv[i]   = 1'b1;
      left[i] = 0;
    end
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (left[i] == 0) begin
          lv[i] = ~lv[i];
          if (i == 2) begin
            if (!lv[i]) left[i] = $urandom_range(1, 4);
            else if ($urandom_range(0, 99) < 8) left[i] = $urandom_range(260, 300);
            else left[i] = run_length(trip_eff, 2);
          end else begin
            left[i] = lv[i] ? run_length(trip_eff, 2) : run_length(rel_eff, 3);
          end
        end
        left[i]--;
      end
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        bits = 4'($urandom_range(0, 15));
        pending_words.push_back(req_word_t'(bits));
      end else if (roll < noise_pct + reset_pct) begin
        push_word(lsi_pkg::ReqReset, lv[0], lv[1], lv[2]);
      end else begin
        push_word(lsi_pkg::ReqTick, lv[0], lv[1], lv[2]);
      end
    end
  endtask

  // every queued word taken and every status word back
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_bus.valid === 1'b1 || awaited_status.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic [lsi_pkg::CfgIdxW-1:0] idx, logic [lsi_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lsi_pkg::RegTripCount) trip_cfg = data;
    else if (idx == lsi_pkg::RegReleaseCount) rel_cfg = data;
  endtask

  // registers change only with the block idle
  task automatic set_registers(logic [lsi_pkg::CfgW-1:0] trip, logic [lsi_pkg::CfgW-1:0] rel);
    wait_drained();
    write_reg(lsi_pkg::RegTripCount, trip);
    write_reg(lsi_pkg::RegReleaseCount, rel);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = lsi_pkg::RegTripCount;
    cfg_data_i       = '0;
    in_bus.valid     = 1'b0;
    in_bus.req_type  = lsi_pkg::ReqTick;
    in_bus.cw_level  = 1'b0;
    in_bus.ccw_level = 1'b0;
    in_bus.org_level = 1'b0;
    out_bus.ready    = 1'b0;

    trip_cfg     = lsi_pkg::TripCountRst;
    rel_cfg      = lsi_pkg::ReleaseCountRst;
    cw_trip_cnt  = 8'd0;
    ccw_trip_cnt = 8'd0;
    cw_rel_cnt   = 8'd0;
    ccw_rel_cnt  = 8'd0;
    org_cnt      = 8'd0;
    cw_lock      = 1'b0;
    ccw_lock     = 1'b0;
    cw_armed     = 1'b1;
    ccw_armed    = 1'b1;
    org_seen     = 1'b0;
    alarm        = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values written back explicitly, then the directed words
    set_registers(lsi_pkg::TripCountRst, lsi_pkg::ReleaseCountRst);
    push_word(lsi_pkg::ReqReset, 1'b0, 1'b0, 1'b0);              // reset with nothing latched
    repeat (4) push_word(lsi_pkg::ReqTick, 1'b0, 1'b0, 1'b1);    // one origin pulse, then none
    push_word(lsi_pkg::ReqTick, 1'b0, 1'b0, 1'b0);               // origin released
    repeat (3) push_word(lsi_pkg::ReqTick, 1'b1, 1'b1, 1'b0);    // both ends trip together
    push_word(lsi_pkg::ReqTick, 1'b1, 1'b1, 1'b0);               // held after the trip
    push_word(lsi_pkg::ReqReset, 1'b1, 1'b0, 1'b1);              // pressed cw end stays locked
    repeat (2) push_word(lsi_pkg::ReqTick, 1'b0, 1'b0, 1'b0);    // cw waits for release count
    repeat (3) push_word(lsi_pkg::ReqTick, 1'b0, 1'b1, 1'b1);    // ccw trips
    push_word(lsi_pkg::ReqReset, 1'b0, 1'b1, 1'b0);              // pressed ccw end stays locked
    repeat (3) push_word(lsi_pkg::ReqTick, 1'b1, 1'b0, 1'b0);    // cw trips with ccw disarmed
    queue_random(250, 12, 3);

    // shortest thresholds, with the long result-side hold-off
    set_registers(8'd1, 8'd1);
    hold_req = 1'b1;
    queue_random(150, 12, 3);

    // longest thresholds: clean runs only, so the counters reach the top
    set_registers(8'd255, 8'd255);
    queue_random(400, 0, 0);

    // zero thresholds behave as one
    set_registers(8'd0, 8'd0);
    queue_random(100, 12, 3);

    // a stretch with no idling on either side
    set_registers(8'd2, 8'd5);
    calm = 1'b1;
    queue_random(150, 12, 3);

    set_registers(lsi_pkg::CfgW'($urandom_range(1, 12)), lsi_pkg::CfgW'($urandom_range(1, 30)));
    calm = 1'b0;
    queue_random(150, 12, 3);

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
